// ===== hw/rtl/lfr_pkg.sv =====
// Shared types and constants for the LED fade-with-resend brightness engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lfr_pkg;

   // Field widths fixed by the item format
   localparam int KIND_W     = 2;
   localparam int ELAPSED_W  = 16;
   localparam int LEVEL_W    = 13;
   localparam int DECAY_W    = 16;
   localparam int RESEND_W   = 2;
   localparam int RATE_W     = 32;

   // Brightness fraction bits, default for the top-level parameter
   localparam int FRAC_BITS_DEF = 20;

   // Level constants in 1/4096 steps
   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 13'd4096;
   localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 13'd0;

   // Resend counter codes
   localparam logic [RESEND_W-1:0] RESEND_SETTLED = 2'd3;
   localparam logic [RESEND_W-1:0] RESEND_CHANGED = 2'd2;
   localparam logic [RESEND_W-1:0] RESEND_NONE    = 2'd0;

   // Configuration register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_DECAY_RATE = 1'b0;   // word index, paddr[2]
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd2560;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_PULSE = 2'd1,
      KIND_SET   = 2'd2,
      KIND_SENT  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_APPLY,
      ST_FINISH
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted transaction
      logic eval;      // difference to goal, decay times elapsed
      logic mul;       // rate times difference magnitude
      logic apply;     // update level state by kind
      logic finish;    // settle resend count, load result register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     rsp_stall;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lfr_req_if.sv =====
// Request channel of the brightness engine: valid/ready plus item fields.
// Depends on lfr_pkg for field widths.
`default_nettype none

interface lfr_req_if;
   import lfr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [ELAPSED_W-1:0] elapsed_time;
   logic [LEVEL_W-1:0]   level_value;
   logic [LEVEL_W-1:0]   end_level;

   modport source (output valid, kind, elapsed_time, level_value, end_level,
                   input ready);
   modport sink   (input valid, kind, elapsed_time, level_value, end_level,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lfr_rsp_if.sv =====
// Result channel of the brightness engine: valid/ready plus result fields.
// Depends on lfr_pkg for field widths.
`default_nettype none

interface lfr_rsp_if;
   import lfr_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] brightness_level;
   logic               needs_send;

   modport source (output valid, brightness_level, needs_send, input ready);
   modport sink   (input valid, brightness_level, needs_send, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lfr_ctrl.sv =====
// Sequencing state machine of the brightness engine.
// Depends on lfr_pkg; drives the datapath through dp_cmd_type.
`default_nettype none

module lfr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire lfr_pkg::dp_status_type status,
   output lfr_pkg::dp_cmd_type        cmd
);
   import lfr_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = (status.kind == KIND_TICK) ? ST_MUL : ST_APPLY;
         end
         ST_MUL: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = !status.rsp_stall;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lfr_datapath.sv =====
// Datapath of the brightness engine: level state, shared multiplier,
// clamp and resend logic, result register. Depends on lfr_pkg.
`default_nettype none

module lfr_datapath #(
   parameter int FRAC_BITS = lfr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lfr_pkg::dp_cmd_type           cmd,
   output lfr_pkg::dp_status_type             status,
   input  wire logic [lfr_pkg::DECAY_W-1:0]   decay_rate,
   input  wire logic [lfr_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [lfr_pkg::ELAPSED_W-1:0] req_elapsed_time,
   input  wire logic [lfr_pkg::LEVEL_W-1:0]   req_level_value,
   input  wire logic [lfr_pkg::LEVEL_W-1:0]   req_end_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [lfr_pkg::LEVEL_W-1:0]        rsp_brightness_level,
   output logic                               rsp_needs_send
);
   import lfr_pkg::*;

   localparam int LW        = FRAC_BITS + 1;          // level width, full = 2^FRAC_BITS
   localparam int LVL_SHIFT = FRAC_BITS - 12;
   localparam int MB_W      = (LW > ELAPSED_W) ? LW : ELAPSED_W;
   localparam int PROD_W    = RATE_W + MB_W;
   localparam int DELTA_W   = PROD_W - 24;
   localparam int SUM_W     = DELTA_W + 1;
   localparam logic [LW-1:0] ONE  = LW'(1) << FRAC_BITS;
   localparam logic [LW-1:0] STEP = LW'(1) << LVL_SHIFT;
   localparam logic [LW-1:0] HALF = LW'(1) << (FRAC_BITS - 13);

   // Absolute difference of two levels
   function automatic logic [LW-1:0] abs_diff(input logic [LW-1:0] a,
                                              input logic [LW-1:0] b);
      logic [LW-1:0] r;
      r = (a >= b) ? (a - b) : (b - a);
      return r;
   endfunction

   // Captured transaction
   kind_type             kind_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [LEVEL_W-1:0]   lv_ff;
   logic [LEVEL_W-1:0]   endl_ff;
   logic [LEVEL_W-1:0]   lv_sat;
   logic [LEVEL_W-1:0]   endl_sat;

   // Level state
   logic [LW-1:0]        now_ff,  now_in;
   logic [LW-1:0]        goal_ff, goal_in;
   logic [LW-1:0]        last_ff, last_in;
   logic [RESEND_W-1:0]  resend_ff, resend_in;

   // Tick intermediates
   logic [LW-1:0]        diff_mag_ff;
   logic                 diff_neg_ff;
   logic [RATE_W-1:0]    rate_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 chk_ff, chk_in;

   // Result register
   logic                 rsp_valid_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;
   logic                 rsp_send_ff;

   // Shared multiplier: decay x elapsed in eval, rate x |diff| otherwise
   logic [RATE_W-1:0]    mul_a;
   logic [MB_W-1:0]      mul_b;
   logic [PROD_W-1:0]    mul_out;

   logic [LEVEL_W-1:0]   cur_lvl;
   logic [LW-1:0]        lv_q;
   logic [LW-1:0]        endl_q;
   logic [DELTA_W-1:0]   delta;
   logic [SUM_W-1:0]     now_ext;
   logic [SUM_W-1:0]     up_sum;
   logic [LW-1:0]        tick_next;
   logic [RESEND_W-1:0]  resend_fin;
   logic                 send_fin;

   // Saturate levels above full
   assign lv_sat   = (req_level_value > LEVEL_FULL) ? LEVEL_FULL : req_level_value;
   assign endl_sat = (req_end_level   > LEVEL_FULL) ? LEVEL_FULL : req_end_level;

   assign mul_a   = cmd.eval ? RATE_W'(decay_rate) : rate_ff;
   assign mul_b   = cmd.eval ? MB_W'(elapsed_ff) : MB_W'(diff_mag_ff);
   assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign cur_lvl = now_ff[LW-1:LVL_SHIFT];
   assign lv_q    = LW'(lv_ff) << LVL_SHIFT;
   assign endl_q  = LW'(endl_ff) << LVL_SHIFT;

   // Step toward the goal with clamping to 0..full
   assign delta   = prod_ff[PROD_W-1:24];
   assign now_ext = SUM_W'(now_ff);
   assign up_sum  = now_ext + SUM_W'(delta);
   always_comb begin
      if (diff_neg_ff) begin
         tick_next = (SUM_W'(delta) > now_ext) ? '0 : LW'(now_ext - SUM_W'(delta));
      end else begin
         tick_next = (up_sum > SUM_W'(ONE)) ? ONE : LW'(up_sum);
      end
   end

   // Level state update by kind
   always_comb begin
      now_in    = now_ff;
      goal_in   = goal_ff;
      last_in   = last_ff;
      resend_in = resend_ff;
      chk_in    = chk_ff;
      if (cmd.apply) begin
         chk_in = 1'b0;
         unique case (kind_ff)
            KIND_TICK: begin
               if (diff_mag_ff >= STEP) begin
                  if (decay_rate != '0) begin
                     now_in = tick_next;
                     chk_in = 1'b1;
                  end else begin
                     now_in    = goal_ff;
                     resend_in = RESEND_CHANGED;
                  end
               end
            end
            KIND_PULSE: begin
               if (lv_ff != cur_lvl) resend_in = RESEND_CHANGED;
               if (lv_q > now_ff) now_in = lv_q;
               goal_in = endl_q;
            end
            KIND_SET: begin
               if (lv_ff != cur_lvl) begin
                  resend_in = (lv_ff == LEVEL_ZERO) ? RESEND_SETTLED : RESEND_CHANGED;
               end
               now_in  = lv_q;
               goal_in = lv_q;
            end
            KIND_SENT: begin
               last_in = now_ff;
               if (resend_ff != RESEND_NONE) resend_in = resend_ff - RESEND_W'(1);
            end
            default: begin
               now_in = now_ff;
            end
         endcase
      end else if (cmd.finish) begin
         resend_in = resend_fin;
      end
   end

   // Resend count after a decay step, and the send flag
   assign resend_fin = !chk_ff ? resend_ff :
                       (abs_diff(goal_ff, now_ff) < STEP) ? RESEND_SETTLED : RESEND_CHANGED;
   assign send_fin   = (abs_diff(now_ff, last_ff) >= HALF) || (resend_fin != RESEND_NONE);

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         goal_ff      <= '0;
         last_ff      <= ONE;
         resend_ff    <= RESEND_CHANGED;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff    <= now_in;
         goal_ff   <= goal_in;
         last_ff   <= last_in;
         resend_ff <= resend_in;
         chk_ff    <= chk_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= kind_type'(req_kind);
         elapsed_ff <= req_elapsed_time;
         lv_ff      <= lv_sat;
         endl_ff    <= endl_sat;
      end
      if (cmd.eval) begin
         diff_neg_ff <= goal_ff < now_ff;
         diff_mag_ff <= abs_diff(goal_ff, now_ff);
         rate_ff     <= mul_out[RATE_W-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= mul_out;
      end
      if (cmd.finish) begin
         rsp_level_ff <= now_ff[LW-1:LVL_SHIFT];
         rsp_send_ff  <= send_fin;
      end
   end

   assign status.kind      = kind_ff;
   assign status.rsp_stall = rsp_valid_ff && !rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_brightness_level = rsp_level_ff;
   assign rsp_needs_send       = rsp_send_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/led_fade_with_resend_top.sv =====
// LED fade-with-resend engine. After the accept edge a tick passes through the
// eval, mul, apply and finish states, other kinds skip mul; the shared multiplier
// is used twice per tick. A new item is accepted only back in the idle state.
// A finished result waits in an output register; the next item is accepted
// meanwhile. Synchronous reset: level 0, goal 0, last sent full, resends 2,
// decay rate 10.0/s.
// Depends on lfr_pkg, lfr_req_if, lfr_rsp_if, lfr_ctrl, lfr_datapath.
`default_nettype none

module led_fade_with_resend_top #(
   parameter int FRAC_BITS = lfr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lfr_req_if.sink                              req_chan,
   lfr_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [lfr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [lfr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lfr_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import lfr_pkg::*;

   logic [DECAY_W-1:0] decay_ff;
   logic               csr_wr;
   dp_cmd_type         cmd;
   dp_status_type      status;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_DECAY_RATE);

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_RESET;
      end else if (csr_wr) begin
         decay_ff <= csr_pwdata[DECAY_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_DECAY_RATE) ? CSR_DATA_W'(decay_ff) : '0;

   lfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfr_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .decay_rate           (decay_ff),
      .req_kind             (req_chan.kind),
      .req_elapsed_time     (req_chan.elapsed_time),
      .req_level_value      (req_chan.level_value),
      .req_end_level        (req_chan.end_level),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_brightness_level (rsp_chan.brightness_level),
      .rsp_needs_send       (rsp_chan.needs_send)
   );

endmodule

`default_nettype wire
